// ----- rtl/cal_pkg.sv -----
`default_nettype none
package cal_pkg;

    localparam int CAPACITY = 64;
    localparam int ELEM_W   = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int MODE_W   = 3;

    // Operation codes carried by the mode field. Code seven is unused.
    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND    = 3'd0,
        MODE_POP_BACK  = 3'd1,
        MODE_POP_FRONT = 3'd2,
        MODE_ERASE     = 3'd3,
        MODE_EXTRACT   = 3'd4,
        MODE_READ      = 3'd5,
        MODE_CLEAR     = 3'd6
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FETCH,
        ST_SHIFT,
        ST_DONE
    } t_state;

    // One access to the element memory: a write port and a read port.
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [ELEM_W-1:0] wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } t_mem_req;

    typedef struct packed {
        logic              ok;
        logic [ELEM_W-1:0] data;
        logic [CNT_W-1:0]  count;
    } t_result;

endpackage
`default_nettype wire

// ----- rtl/cal_mem.sv -----
`default_nettype none
module cal_mem (
    input  wire logic                      i_clk,
    input  wire cal_pkg::t_mem_req         i_req,
    output logic [cal_pkg::ELEM_W-1:0]     o_rdata
);

    logic [cal_pkg::ELEM_W-1:0] r_mem [cal_pkg::CAPACITY];
    logic [cal_pkg::ELEM_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ----- rtl/cal_seq.sv -----
`default_nettype none
module cal_seq (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [cal_pkg::MODE_W-1:0]    i_mode,
    input  wire logic [cal_pkg::IDX_W-1:0]     i_index,
    input  wire logic [cal_pkg::ELEM_W-1:0]    i_data_in,
    output cal_pkg::t_mem_req                  o_mem_req,
    input  wire logic [cal_pkg::ELEM_W-1:0]    i_rdata,
    output logic                               o_res_valid,
    output cal_pkg::t_result                   o_res,
    input  wire logic                          i_res_ready
);

    cal_pkg::t_state              r_state, n_state;
    cal_pkg::t_mode               r_mode, n_mode;
    logic [cal_pkg::IDX_W-1:0]    r_pos, n_pos;
    logic [cal_pkg::ELEM_W-1:0]   r_din, n_din;
    logic [cal_pkg::CNT_W-1:0]    r_count, n_count;
    logic                         r_ok, n_ok;
    logic [cal_pkg::ELEM_W-1:0]   r_dout, n_dout;

    logic [cal_pkg::CNT_W-1:0]    w_sum;
    logic                         w_more;
    logic                         w_hit;
    logic                         w_remove;
    logic [cal_pkg::CNT_W-1:0]    w_last;

    // The shared add and compare unit: position plus one or two against the count.
    // It decides whether another element must move down during compaction.
    always_comb begin
        w_sum  = {1'b0, r_pos} + ((r_state == cal_pkg::ST_SHIFT) ?
                 cal_pkg::CNT_W'(2) : cal_pkg::CNT_W'(1));
        w_more = (w_sum < r_count);
        w_last = r_count - cal_pkg::CNT_W'(1);
    end

    always_comb begin
        w_hit = 1'b0;
        case (r_mode)
            cal_pkg::MODE_POP_BACK,
            cal_pkg::MODE_POP_FRONT: w_hit = (r_count != '0);
            cal_pkg::MODE_ERASE,
            cal_pkg::MODE_EXTRACT,
            cal_pkg::MODE_READ:      w_hit = ({1'b0, r_pos} < r_count);
            default:                 w_hit = 1'b0;
        endcase
        w_remove = (r_mode == cal_pkg::MODE_POP_FRONT) || (r_mode == cal_pkg::MODE_ERASE)
                   || (r_mode == cal_pkg::MODE_EXTRACT);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            cal_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = cal_pkg::ST_EXEC;
                end
            end
            cal_pkg::ST_EXEC: begin
                n_state = w_hit ? cal_pkg::ST_FETCH : cal_pkg::ST_DONE;
            end
            cal_pkg::ST_FETCH: begin
                n_state = (w_remove && w_more) ? cal_pkg::ST_SHIFT : cal_pkg::ST_DONE;
            end
            cal_pkg::ST_SHIFT: begin
                n_state = w_more ? cal_pkg::ST_SHIFT : cal_pkg::ST_DONE;
            end
            cal_pkg::ST_DONE: begin
                if (i_res_ready) begin
                    n_state = cal_pkg::ST_IDLE;
                end
            end
            default: n_state = cal_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_mode    = r_mode;
        n_pos     = r_pos;
        n_din     = r_din;
        n_count   = r_count;
        n_ok      = r_ok;
        n_dout    = r_dout;
        o_mem_req = '0;
        case (r_state)
            cal_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_mode = cal_pkg::t_mode'(i_mode);
                    n_pos  = i_index;
                    n_din  = i_data_in;
                    n_ok   = 1'b0;
                    n_dout = '0;
                end
            end
            cal_pkg::ST_EXEC: begin
                case (r_mode)
                    cal_pkg::MODE_APPEND: begin
                        if (r_count < cal_pkg::CNT_W'(cal_pkg::CAPACITY)) begin
                            o_mem_req.we    = 1'b1;
                            o_mem_req.waddr = r_count[cal_pkg::IDX_W-1:0];
                            o_mem_req.wdata = r_din;
                            n_count         = r_count + cal_pkg::CNT_W'(1);
                            n_ok            = 1'b1;
                        end
                    end
                    cal_pkg::MODE_POP_BACK: begin
                        n_pos = w_last[cal_pkg::IDX_W-1:0];
                    end
                    cal_pkg::MODE_POP_FRONT: begin
                        n_pos = '0;
                    end
                    cal_pkg::MODE_CLEAR: begin
                        n_count = '0;
                        n_ok    = 1'b1;
                    end
                    default: ;
                endcase
                if (w_hit) begin
                    o_mem_req.re    = 1'b1;
                    o_mem_req.raddr = (r_mode == cal_pkg::MODE_POP_BACK) ?
                                      w_last[cal_pkg::IDX_W-1:0] :
                                      ((r_mode == cal_pkg::MODE_POP_FRONT) ? '0 : r_pos);
                    n_ok            = 1'b1;
                end
            end
            cal_pkg::ST_FETCH: begin
                n_dout = (r_mode == cal_pkg::MODE_ERASE) ? '0 : i_rdata;
                if (w_remove && w_more) begin
                    o_mem_req.re    = 1'b1;
                    o_mem_req.raddr = w_sum[cal_pkg::IDX_W-1:0];
                end else if (r_mode != cal_pkg::MODE_READ) begin
                    n_count = w_last;
                end
            end
            cal_pkg::ST_SHIFT: begin
                // The element read last cycle moves down into the current position.
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = r_pos;
                o_mem_req.wdata = i_rdata;
                n_pos           = r_pos + cal_pkg::IDX_W'(1);
                if (w_more) begin
                    o_mem_req.re    = 1'b1;
                    o_mem_req.raddr = w_sum[cal_pkg::IDX_W-1:0];
                end else begin
                    n_count = w_last;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cal_pkg::ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode <= n_mode;
        r_pos  <= n_pos;
        r_din  <= n_din;
        r_ok   <= n_ok;
        r_dout <= n_dout;
    end

    assign o_stall     = (r_state != cal_pkg::ST_IDLE);
    assign o_res_valid = (r_state == cal_pkg::ST_DONE);
    assign o_res.ok    = r_ok;
    assign o_res.data  = r_dout;
    assign o_res.count = r_count;

endmodule
`default_nettype wire

// ----- rtl/compacting_array_list_core.sv -----
`default_nettype none
// Fixed-capacity ordered list of 32-bit elements, packed from position 0. Each
// input item carries one operation (append, pop back, pop front, erase, extract,
// read or clear) and yields exactly one result item with a success flag, the
// element read (zero for erase, when nothing is read or the operation fails), the
// count after the operation, and empty and full flags. The block works on one item
// at a time: it stalls its input from acceptance until the result has moved into
// the output register. Append, clear and failed operations need no memory read;
// read and pop back add one read, and pop front, erase and extract also move each
// element behind the removed one down, and this compaction sets a removal's length:
// a single-port-read element memory moves one element down per cycle, with a shared
// adder and comparator finding the next element to read. A new item may be accepted
// while the previous result still waits in the output register.
module compacting_array_list_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [cal_pkg::MODE_W-1:0]    i_mode,
    input  wire logic [cal_pkg::IDX_W-1:0]     i_index,
    input  wire logic [cal_pkg::ELEM_W-1:0]    i_data_in,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic                               o_ok,
    output logic [cal_pkg::ELEM_W-1:0]         o_data_out,
    output logic [cal_pkg::CNT_W-1:0]          o_count,
    output logic                               o_is_empty,
    output logic                               o_is_full
);

    cal_pkg::t_mem_req           w_mem_req;
    logic [cal_pkg::ELEM_W-1:0]  w_rdata;
    logic                        w_res_valid;
    logic                        w_res_ready;
    cal_pkg::t_result            w_res;

    logic                        r_out_valid, n_out_valid;
    cal_pkg::t_result            r_out, n_out;

    // The sequencer owns the count and the operation; the memory holds elements.
    cal_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_mode      (i_mode),
        .i_index     (i_index),
        .i_data_in   (i_data_in),
        .o_mem_req   (w_mem_req),
        .i_rdata     (w_rdata),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_ready (w_res_ready)
    );

    cal_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (w_mem_req),
        .o_rdata (w_rdata)
    );

    // The output register takes a finished result when it is empty or being drained.
    assign w_res_ready = !r_out_valid || !i_stall;

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (w_res_valid && w_res_ready) begin
            n_out_valid = 1'b1;
            n_out       = w_res;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid    = r_out_valid;
    assign o_ok       = r_out.ok;
    assign o_data_out = r_out.data;
    assign o_count    = r_out.count;
    assign o_is_empty = (r_out.count == '0);
    assign o_is_full  = (r_out.count == cal_pkg::CNT_W'(cal_pkg::CAPACITY));

    // The count reported never exceeds the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_count <= cal_pkg::CNT_W'(cal_pkg::CAPACITY)))
        else $error("count above capacity");

    // A failed operation never returns element data.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_ok) |-> (o_data_out == '0))
        else $error("data on failed operation");

    // A result handed over by the sequencer shows up on the output next cycle.
    a_handover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_valid && w_res_ready) |=> o_valid)
        else $error("result lost at output register");

endmodule
`default_nettype wire
